@@ design/grid_linear_interpolator_assert.svh @@
// Assertion macros for the grid linear interpolator.
`ifndef GRID_LINEAR_INTERPOLATOR_ASSERT_SVH
`define GRID_LINEAR_INTERPOLATOR_ASSERT_SVH

// Antecedent holds, consequent must hold in the same cycle.
`define GLI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds, consequent must hold in the next cycle.
`define GLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/glint_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and constants of the grid linear interpolator.
package glint_pkg;

	localparam int VW = 32;
	localparam int IDXW = 10;
	localparam int KW = 12;
	localparam int PW = 2 * (VW + 1);
	localparam int GRID_DEPTH_DEF = 1024;
	localparam logic [IDXW-1:0] LAST_POINT_RST = 10'd1023;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_INTERP = 2'd1;
	localparam logic [1:0] FUNC_ZERO = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BELOW = 3'd1;
	localparam logic [2:0] ST_ABOVE = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_NOZERO = 3'd4;

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	typedef struct packed {
		logic [1:0] func;
		logic [IDXW-1:0] point_index;
		logic signed [VW-1:0] x_value;
		logic signed [VW-1:0] y_value;
	} in_t;

	typedef struct packed {
		logic signed [VW-1:0] result_value;
		logic signed [KW-1:0] interval_index;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		logic signed [VW-1:0] base;
		logic signed [VW-1:0] b1;
		logic signed [VW-1:0] t0;
		logic signed [VW-1:0] tq;
		logic signed [VW-1:0] t1;
	} lerp_req_t;

endpackage

@@ design/glint_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with a registered read.
module glint_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/glint_lerp.sv @@
`timescale 1ns / 1ps
// Linear interpolation unit: multiply, bit-serial restoring divide, saturate.
module glint_lerp (
	input logic clk,
	input logic arst_n,
	input logic start,
	input glint_pkg::lerp_req_t req,
	output logic done,
	output logic signed [glint_pkg::VW-1:0] value
);
	import glint_pkg::*;

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_MUL = 4'b0010,
		L_DIV = 4'b0100,
		L_SAT = 4'b1000
	} lstate_t;

	lstate_t state_q;
	logic [VW:0] m1_q, m2_q, m3_q;
	logic neg_q;
	logic signed [VW-1:0] base_q;
	logic [PW-1:0] num_q;
	logic [VW:0] rem_q;
	logic [$clog2(PW)-1:0] cnt_q;
	logic done_q;
	logic signed [VW-1:0] value_q;

	logic signed [VW:0] d1, d2, d3;
	logic [VW+1:0] rem_sh;
	logic rem_ge;
	logic [VW:0] room_pos, room_neg;
	logic [PW-1:0] room_pos_w, room_neg_w;
	logic signed [VW-1:0] sat_val;

	always_comb begin
		d1 = {req.tq[VW-1], req.tq} - {req.t0[VW-1], req.t0};
		d2 = {req.b1[VW-1], req.b1} - {req.base[VW-1], req.base};
		d3 = {req.t1[VW-1], req.t1} - {req.t0[VW-1], req.t0};
		rem_sh = {rem_q, num_q[PW-1]};
		rem_ge = rem_sh >= {1'b0, m3_q};
		room_pos = {1'b0, VMAX} - {base_q[VW-1], base_q};
		room_neg = {base_q[VW-1], base_q} - {VMIN[VW-1], VMIN};
		room_pos_w = PW'(room_pos);
		room_neg_w = PW'(room_neg);
		if (!neg_q) begin
			sat_val = (num_q > room_pos_w) ? VMAX : VW'(base_q + $signed(num_q[VW-1:0]));
		end else begin
			sat_val = (num_q > room_neg_w) ? VMIN : VW'(base_q - $signed(num_q[VW-1:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					cnt_q <= '0;
					if (m3_q == '0) begin
						done_q <= 1'b1;
						state_q <= L_IDLE;
					end else begin
						state_q <= L_DIV;
					end
				end
				L_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ($clog2(PW))'(PW - 1)) begin
						state_q <= L_SAT;
					end
				end
				L_SAT: begin
					done_q <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					m1_q <= d1[VW] ? VW'(0) - d1 : d1;
					m2_q <= d2[VW] ? VW'(0) - d2 : d2;
					m3_q <= d3[VW] ? VW'(0) - d3 : d3;
					neg_q <= d1[VW] ^ d2[VW] ^ d3[VW];
					base_q <= req.base;
				end
			end
			L_MUL: begin
				num_q <= m1_q * m2_q;
				rem_q <= '0;
				value_q <= base_q;
			end
			L_DIV: begin
				rem_q <= rem_ge ? (VW + 1)'(rem_sh - {1'b0, m3_q}) : rem_sh[VW:0];
				num_q <= {num_q[PW-2:0], rem_ge};
			end
			L_SAT: begin
				value_q <= sat_val;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign value = value_q;

endmodule

@@ design/grid_linear_interpolator.sv @@
// Piecewise linear interpolation and zero search over a stored grid of points.
// A load gives no result. A query reads one grid point per cycle from point 0;
// an interpolation or a secant root then goes to the lerp unit and its serial divider.
// The result is registered, and busy holds off the next item until it appears.
// Reset clears the control state and sets last_point_index to 1023; the grid is undefined.
`timescale 1ns / 1ps
module grid_linear_interpolator #(
	parameter int GRID_DEPTH = glint_pkg::GRID_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input glint_pkg::in_t cmd,
	output logic done,
	output glint_pkg::result_t result,
	input logic cfg_wr_en,
	input logic [glint_pkg::IDXW-1:0] cfg_wr_data
);
	import glint_pkg::*;
	`include "grid_linear_interpolator_assert.svh"

	localparam int AW = $clog2(GRID_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_LERP = 3'b100
	} state_t;

	state_t state_q;
	logic [IDXW-1:0] lpi_q;
	logic [AW-1:0] n_q, ptr_q, idx_q;
	logic rv_q, zph_q, zero_q, done_q;
	logic signed [VW-1:0] q_q, xp_q, yp_q;
	logic signed [KW-1:0] k_q;
	result_t result_q;

	logic accept, load_we, query_go;
	logic [AW-1:0] n_next, raddr;
	logic [2*VW-1:0] rdata;
	logic signed [VW-1:0] xc, yc;
	logic fin, lerp_go, found, idx_is_n, sign_chg;
	logic signed [VW-1:0] fin_res;
	logic signed [KW-1:0] fin_k, k_found, k_above, kk;
	logic [2:0] fin_st;
	lerp_req_t lreq;
	logic lerp_done;
	logic signed [VW-1:0] lerp_val;

	assign accept = start && !busy;
	assign busy = state_q != S_IDLE;
	assign query_go = accept && (cmd.func == FUNC_INTERP || cmd.func == FUNC_ZERO);
	assign load_we = accept && cmd.func == FUNC_LOAD && 32'(cmd.point_index) < GRID_DEPTH;
	assign n_next = (32'(lpi_q) > GRID_DEPTH - 1) ? AW'(GRID_DEPTH - 1) : AW'(lpi_q);
	assign raddr = ptr_q;

	glint_ram #(
		.WIDTH(2 * VW),
		.DEPTH(GRID_DEPTH)
	) u_grid (
		.clk(clk),
		.we(load_we),
		.waddr(AW'(cmd.point_index)),
		.wdata({cmd.x_value, cmd.y_value}),
		.raddr(raddr),
		.rdata(rdata)
	);

	glint_lerp u_lerp (
		.clk(clk),
		.arst_n(arst_n),
		.start(lerp_go),
		.req(lreq),
		.done(lerp_done),
		.value(lerp_val)
	);

	always_comb begin
		xc = $signed(rdata[2*VW-1:VW]);
		yc = $signed(rdata[VW-1:0]);
		idx_is_n = idx_q == n_q;
		k_found = KW'(idx_q) - KW'(1);
		k_above = KW'(n_q) + KW'(1);
		kk = zph_q ? k_q : k_found;
		sign_chg = (yp_q > 0 && yc < 0) || (yp_q < 0 && yc > 0);
		fin = 1'b0;
		lerp_go = 1'b0;
		found = 1'b0;
		fin_res = '0;
		fin_k = k_q;
		fin_st = ST_OK;
		lreq = '{base: yp_q, b1: yc, t0: xp_q, tq: q_q, t1: xc};
		if (state_q == S_SCAN && rv_q) begin
			if (idx_q == '0) begin
				if (q_q < xc) begin
					fin = 1'b1;
					fin_k = '1;
					fin_res = zero_q ? '0 : yc;
					fin_st = zero_q ? ST_RANGE : ST_BELOW;
				end else if (n_q == '0) begin
					fin = 1'b1;
					fin_k = k_above;
					fin_res = zero_q ? '0 : yc;
					fin_st = zero_q ? ST_RANGE : ST_ABOVE;
				end
			end else if (!zph_q && q_q > xc) begin
				if (idx_is_n) begin
					fin = 1'b1;
					fin_k = k_above;
					fin_res = zero_q ? '0 : yc;
					fin_st = zero_q ? ST_RANGE : ST_ABOVE;
				end
			end else begin
				found = !zph_q;
				fin_k = kk;
				if (!zph_q && !zero_q) begin
					lerp_go = 1'b1;
				end else if (sign_chg) begin
					lerp_go = 1'b1;
					lreq = '{base: xp_q, b1: xc, t0: yp_q, tq: '0, t1: yc};
				end else if (idx_is_n) begin
					fin = 1'b1;
					fin_st = ST_NOZERO;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lpi_q <= LAST_POINT_RST;
			rv_q <= 1'b0;
			zph_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr_en) begin
				lpi_q <= cfg_wr_data;
			end
			case (state_q)
				S_IDLE: begin
					rv_q <= 1'b0;
					zph_q <= 1'b0;
					if (query_go) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rv_q <= 1'b1;
					if (found) begin
						zph_q <= 1'b1;
					end
					if (fin) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
						rv_q <= 1'b0;
					end else if (lerp_go) begin
						state_q <= S_LERP;
						rv_q <= 1'b0;
					end
				end
				S_LERP: begin
					if (lerp_done) begin
						state_q <= S_IDLE;
						done_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ptr_q <= '0;
				n_q <= n_next;
				q_q <= cmd.x_value;
				zero_q <= cmd.func == FUNC_ZERO;
			end
			S_SCAN: begin
				ptr_q <= ptr_q + 1'b1;
				idx_q <= ptr_q;
				if (rv_q) begin
					xp_q <= xc;
					yp_q <= yc;
				end
				if (found || lerp_go || fin) begin
					k_q <= fin_k;
				end
				if (fin) begin
					result_q <= '{result_value: fin_res, interval_index: fin_k,
						status: fin_st};
				end
			end
			S_LERP: begin
				if (lerp_done) begin
					result_q <= '{result_value: lerp_val, interval_index: k_q, status: ST_OK};
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = result_q;

	`GLI_ASSERT_NEXT(a_query_busy, clk, arst_n, query_go, busy, "Accepted query did not raise busy.")
	`GLI_ASSERT_NEXT(a_single_done, clk, arst_n, done, !done, "Result strobe held too long.")
	`GLI_ASSERT_SAME(a_below_index, clk, arst_n, done && result.status == ST_BELOW,
		result.interval_index == '1, "Clamp below without interval index minus one.")
	`GLI_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "Result delivered while still busy.")

endmodule
